[rtl/mfld_pkg.sv]
// ----------------------------------------------------------------------------
// mfld_pkg: shared definitions for the monochrome line drawer
// Screen geometry, store layout, operation codes and the command word that
// goes from the front end through the queue to the drawing engine.
// ----------------------------------------------------------------------------
package mfld_pkg;

   // screen geometry; the store holds one byte per page and column
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH   = PAGE_COUNT * SCREEN_WIDTH;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   localparam int COORD_W = 8;
   localparam int LEN_W   = COORD_W + 1;

   // port word widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int DONE_BIT   = 8;

   localparam int QUEUE_DEPTH = 2;

   // op codes carried on tuser
   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_LINE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // single pixel actions
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   // command kinds after classification
   localparam logic [2:0] KIND_NOP    = 3'd0;
   localparam logic [2:0] KIND_PIXEL  = 3'd1;
   localparam logic [2:0] KIND_LINE_V = 3'd2;
   localparam logic [2:0] KIND_LINE_H = 3'd3;
   localparam logic [2:0] KIND_LINE_S = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic [1:0]         mode;
      logic [COORD_W-1:0] x;       // start column
      logic [COORD_W-1:0] y;       // start row
      logic [LEN_W-1:0]   len;     // pixels to walk
      logic [COORD_W-1:0] dx;      // sloped line x span
      logic               dy_neg;  // sloped line goes up
      logic [COORD_W-1:0] dy_mag;  // sloped line y span magnitude
      logic [ADDR_W-1:0]  addr;    // store byte for read-back
   } cmd_type;

endpackage

[rtl/mono_framebuffer_line_drawer.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer: monochrome page frame store with line drawing
// Top level: intake, command queue and drawing engine around one byte store.
// ----------------------------------------------------------------------------
// The frame store holds 8 pages x 128 columns, one byte each; pixel (x, y) is
// bit y mod 8 of the byte at page y/8, column x. After reset the engine
// sweeps the store to zero, one byte per cycle, and req_tready stays low
// until it is done. Each request word produces exactly one response word, in
// order. Once the engine takes a word off the queue, a byte read is one
// registered store read, a single pixel is one read-modify-write of its store
// byte through the single-port-write RAM, and a line reads and writes each
// on-screen pixel and only steps past each off-screen pixel; a sloped line
// first runs the bit-serial slope divide. A line walks at most 256 pixels, of
// which at most 128 land on screen. The RAM's read-then-write per pixel sets
// the walk rate. A two-word queue sits ahead of the engine and a response
// register after it, so intake keeps accepting while the engine works and
// while a response waits, until the queue fills.
module mono_framebuffer_line_drawer import mfld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request: x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24],
   //          pixel_mode[33:32], read_page[36:34], read_column[43:37], zeros
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,   // op[1:0]
   // response: read_byte[7:0], done_res[8], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;
   logic    clear_busy;

   // classify incoming words; intake is held off during the clear sweep
   mfld_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .clear_busy (clear_busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mfld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (head_cmd),
      .empty    (queue_empty)
   );

   // engine owns the store and the response register
   mfld_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .clear_busy  (clear_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

[rtl/mfld_ram.sv]
// ----------------------------------------------------------------------------
// mfld_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mfld_front.sv]
// ----------------------------------------------------------------------------
// mfld_front: request intake and classification
// Unpacks a request word, sorts it into a command kind and normalizes line
// end points so the engine only ever walks forward.
// ----------------------------------------------------------------------------
module mfld_front import mfld_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  queue_full,
   input  logic                  clear_busy,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic [COORD_W-1:0] x_start;
   logic [COORD_W-1:0] y_start;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic [1:0]         pixel_mode;
   logic [2:0]         read_page;
   logic [6:0]         read_column;

   logic               swap;
   logic [COORD_W-1:0] xa, ya, xb, yb;

   assign x_start     = req_tdata[7:0];
   assign y_start     = req_tdata[15:8];
   assign x_end       = req_tdata[23:16];
   assign y_end       = req_tdata[31:24];
   assign pixel_mode  = req_tdata[33:32];
   assign read_page   = req_tdata[36:34];
   assign read_column = req_tdata[43:37];

   assign req_tready = !queue_full && !clear_busy;
   assign push       = req_tvalid && req_tready;

   // order sloped and horizontal lines by x
   assign swap = x_end < x_start;
   assign xa   = swap ? x_end   : x_start;
   assign ya   = swap ? y_end   : y_start;
   assign xb   = swap ? x_start : x_end;
   assign yb   = swap ? y_start : y_end;

   always_comb begin
      push_cmd      = '0;
      push_cmd.kind = KIND_NOP;
      push_cmd.mode = MODE_SET;
      unique case (req_tuser)
         OP_PIXEL: begin
            if (pixel_mode == MODE_CLEAR || pixel_mode == MODE_SET ||
                pixel_mode == MODE_INVERT) begin
               push_cmd.kind = KIND_PIXEL;
               push_cmd.mode = pixel_mode;
               push_cmd.x    = x_start;
               push_cmd.y    = y_start;
               push_cmd.len  = LEN_W'(1);
            end
         end
         OP_LINE: begin
            if (x_start == x_end) begin
               // vertical, the larger-y end point excluded
               push_cmd.kind = KIND_LINE_V;
               push_cmd.x    = x_start;
               push_cmd.y    = (y_end < y_start) ? y_end : y_start;
               push_cmd.len  = (y_end < y_start) ? LEN_W'(y_start - y_end)
                                                 : LEN_W'(y_end - y_start);
            end else if (y_start == y_end) begin
               // horizontal, the larger-x end point excluded
               push_cmd.kind = KIND_LINE_H;
               push_cmd.x    = xa;
               push_cmd.y    = y_start;
               push_cmd.len  = LEN_W'(xb - xa);
            end else begin
               push_cmd.kind   = KIND_LINE_S;
               push_cmd.x      = xa;
               push_cmd.y      = ya;
               push_cmd.dx     = xb - xa;
               push_cmd.dy_neg = yb < ya;
               push_cmd.dy_mag = (yb < ya) ? (ya - yb) : (yb - ya);
               push_cmd.len    = LEN_W'(xb - xa) + LEN_W'(1);
            end
         end
         OP_READ: begin
            if (32'(read_page) < PAGE_COUNT && 32'(read_column) < SCREEN_WIDTH) begin
               push_cmd.kind = KIND_READ;
               push_cmd.addr = ADDR_W'(32'(read_page) * SCREEN_WIDTH + 32'(read_column));
            end
         end
         default: begin
            push_cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule

[rtl/mfld_queue.sv]
// ----------------------------------------------------------------------------
// mfld_queue: command queue
// Short FIFO between intake and engine so either side can stall alone.
// ----------------------------------------------------------------------------
module mfld_queue import mfld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/mfld_engine.sv]
// ----------------------------------------------------------------------------
// mfld_engine: drawing engine
// Clears the frame store after reset, then runs queued commands: pixel
// read-modify-write, line walks with an iterative slope divide, byte reads.
// Holds the response register.
// ----------------------------------------------------------------------------
module mfld_engine import mfld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  cmd_type               head_cmd,
   output logic                  pop,
   output logic                  clear_busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SLOPE  = 3'd3;
   localparam logic [2:0] ST_WALK   = 3'd4;
   localparam logic [2:0] ST_MODIFY = 3'd5;
   localparam logic [2:0] ST_READ   = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   // control
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // payload
   logic [2:0]         kind_ff, kind_in;
   logic [1:0]         mode_ff, mode_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [COORD_W-1:0] dx_ff, dx_in;
   logic               dy_neg_ff, dy_neg_in;
   logic [COORD_W-1:0] div_rem_ff, div_rem_in;
   logic [COORD_W-1:0] div_quo_ff, div_quo_in;
   logic [2:0]         div_cnt_ff, div_cnt_in;
   logic [LEN_W-1:0]   step_q_ff, step_q_in;   // signed whole y step
   logic [COORD_W-1:0] step_r_ff, step_r_in;   // fractional step numerator
   logic [COORD_W-1:0] acc_ff, acc_in;         // running remainder
   logic [7:0]         res_ff, res_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;

   // RAM
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [7:0]         ram_rdata;

   // datapath
   logic               on_screen;
   logic [ADDR_W-1:0]  pix_addr;
   logic [7:0]         bit_mask;
   logic [7:0]         new_byte;
   logic [COORD_W-1:0] adv_x, adv_y, adv_acc;
   logic [LEN_W-1:0]   adv_len;
   logic [LEN_W-1:0]   frac_sum;
   logic               frac_carry;
   logic [LEN_W:0]     y_sum;
   logic [COORD_W:0]   rem_shift;
   logic               rem_fits;
   logic               rsp_load;

   mfld_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign on_screen = (LEN_W'(x_ff) < LEN_W'(SCREEN_WIDTH)) &&
                      (LEN_W'(y_ff) < LEN_W'(SCREEN_HEIGHT));
   assign pix_addr  = ADDR_W'(32'(y_ff[COORD_W-1:3]) * SCREEN_WIDTH + 32'(x_ff));
   assign bit_mask  = 8'd1 << y_ff[2:0];

   always_comb begin
      case (mode_ff)
         MODE_CLEAR:  new_byte = ram_rdata & ~bit_mask;
         MODE_SET:    new_byte = ram_rdata | bit_mask;
         MODE_INVERT: new_byte = ram_rdata ^ bit_mask;
         default:     new_byte = ram_rdata;
      endcase
   end

   // one step along the current walk
   assign frac_sum   = LEN_W'(acc_ff) + LEN_W'(step_r_ff);
   assign frac_carry = frac_sum >= LEN_W'(dx_ff);
   assign y_sum      = (LEN_W + 1)'(y_ff) + {step_q_ff[LEN_W-1], step_q_ff} +
                       (LEN_W + 1)'(frac_carry);

   always_comb begin
      adv_x   = x_ff;
      adv_y   = y_ff;
      adv_acc = acc_ff;
      adv_len = len_ff - 1'b1;
      case (kind_ff)
         KIND_LINE_V: adv_y = y_ff + 1'b1;
         KIND_LINE_H: adv_x = x_ff + 1'b1;
         KIND_LINE_S: begin
            adv_x   = x_ff + 1'b1;
            adv_y   = y_sum[COORD_W-1:0];
            adv_acc = frac_carry ? COORD_W'(frac_sum - LEN_W'(dx_ff))
                                 : frac_sum[COORD_W-1:0];
         end
         default: adv_x = x_ff;
      endcase
   end

   // restoring divide step, |dy| / dx
   assign rem_shift = {div_rem_ff, div_quo_ff[COORD_W-1]};
   assign rem_fits  = rem_shift >= LEN_W'(dx_ff);

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      kind_in     = kind_ff;
      mode_in     = mode_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      len_in      = len_ff;
      dx_in       = dx_ff;
      dy_neg_in   = dy_neg_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_cnt_in  = div_cnt_ff;
      step_q_in   = step_q_ff;
      step_r_in   = step_r_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = pix_addr;
      ram_wdata   = new_byte;
      ram_raddr   = pix_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            ram_raddr = head_cmd.addr;
            if (!queue_empty) begin
               pop        = 1'b1;
               kind_in    = head_cmd.kind;
               mode_in    = (head_cmd.kind == KIND_PIXEL) ? head_cmd.mode : MODE_SET;
               x_in       = head_cmd.x;
               y_in       = head_cmd.y;
               len_in     = head_cmd.len;
               dx_in      = head_cmd.dx;
               dy_neg_in  = head_cmd.dy_neg;
               div_quo_in = head_cmd.dy_mag;
               div_rem_in = '0;
               div_cnt_in = '0;
               acc_in     = '0;
               step_q_in  = '0;
               step_r_in  = '0;
               res_in     = '0;
               unique case (head_cmd.kind) inside
                  KIND_NOP:    state_in = ST_FINISH;
                  KIND_READ:   state_in = ST_READ;
                  KIND_LINE_S: state_in = ST_DIV;
                  KIND_PIXEL, KIND_LINE_V, KIND_LINE_H: state_in = ST_WALK;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIV: begin
            div_rem_in = rem_fits ? COORD_W'(rem_shift - LEN_W'(dx_ff))
                                  : rem_shift[COORD_W-1:0];
            div_quo_in = {div_quo_ff[COORD_W-2:0], rem_fits};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 3'd7) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            // floor division step for the signed slope
            if (!dy_neg_ff) begin
               step_q_in = LEN_W'(div_quo_ff);
               step_r_in = div_rem_ff;
            end else if (div_rem_ff == '0) begin
               step_q_in = -LEN_W'(div_quo_ff);
               step_r_in = '0;
            end else begin
               step_q_in = -(LEN_W'(div_quo_ff) + 1'b1);
               step_r_in = dx_ff - div_rem_ff;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (len_ff == '0) begin
               state_in = ST_FINISH;
            end else if (on_screen) begin
               state_in = ST_MODIFY;
            end else begin
               x_in   = adv_x;
               y_in   = adv_y;
               acc_in = adv_acc;
               len_in = adv_len;
            end
         end
         ST_MODIFY: begin
            ram_we   = 1'b1;
            x_in     = adv_x;
            y_in     = adv_y;
            acc_in   = adv_acc;
            len_in   = adv_len;
            state_in = ST_WALK;
         end
         ST_READ: begin
            res_in   = ram_rdata;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      mode_ff     <= mode_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      len_ff      <= len_in;
      dx_ff       <= dx_in;
      dy_neg_ff   <= dy_neg_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      step_q_ff   <= step_q_in;
      step_r_ff   <= step_r_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign clear_busy = state_ff == ST_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - DONE_BIT - 1)'(0), 1'b1, rsp_byte_ff};

endmodule

[rtl/mfld_checker.sv]
// ----------------------------------------------------------------------------
// mfld_checker: port-level checks for the line drawer
// Watches handshakes and word counts on the top-level ports.
// ----------------------------------------------------------------------------
module mfld_checker import mfld_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // words taken in but not yet answered: queue, engine, response register
   logic [2:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_done_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DONE_BIT])
      else $error("done flag low on a response");

   a_clear_hold: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clear sweep");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 3'd0)
      else $error("response without a pending request");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more requests in flight than storage allows");

endmodule

bind mono_framebuffer_line_drawer mfld_checker u_mfld_checker (.*);
